// ===== rtl/core/matrix_multiply_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply engine
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MME_ASSERT_NOW(lbl, ante, cons, msg)
`define MME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Command codes, register indexes, fixed widths and control structures.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int CFG_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W = 4;
    localparam int SUM_W = 48;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_code_t;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_BAD
    } state_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic issue;
        logic first;
        logic last_p;
        logic emit;
        logic emit_bad;
        logic last_col;
    } mme_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic out_free;
    } mme_status_t;

endpackage

// ===== rtl/core/mme_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Carries load and compute transactions with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mme_in_if #(
    parameter int ELEM_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [mme_pkg::IDX_W-1:0]   row_index;
    logic [mme_pkg::IDX_W-1:0]   col_index;
    logic signed [ELEM_BITS-1:0] element;

    modport source (
        output valid, cmd, row_index, col_index, element,
        input  ready
    );

    modport sink (
        input  valid, cmd, row_index, col_index, element,
        output ready
    );
endinterface

// ===== rtl/core/mme_out_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Carries product elements and index errors with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mme_out_if;
    logic                             valid;
    logic                             ready;
    logic [mme_pkg::IDX_W-1:0]        out_row;
    logic [mme_pkg::IDX_W-1:0]        out_col;
    logic signed [mme_pkg::SUM_W-1:0] dot_sum;
    logic                             last;
    logic                             bad_index;

    modport source (
        output valid, out_row, out_col, dot_sum, last, bad_index,
        input  ready
    );

    modport sink (
        input  valid, out_row, out_col, dot_sum, last, bad_index,
        output ready
    );
endinterface

// ===== rtl/core/mme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mme_ctrl.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply engine controller
// Holds the size registers, decodes transactions and sequences the
// inner-product loop over columns and inner index.
// ----------------------------------------------------------------------------
module mme_ctrl #(
    parameter int MAX_DIM = 16,
    localparam int DW = $clog2(MAX_DIM),
    localparam int SZW = $clog2(MAX_DIM + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]        cfg_data,
    mme_in_if.sink                           request,
    output mme_pkg::mme_cmd_t                cmd,
    input  mme_pkg::mme_status_t             status,
    output logic [mme_pkg::IDX_W-1:0]        row_sel,
    output logic [DW-1:0]                    p_sel,
    output logic [DW-1:0]                    j_sel
);

    mme_pkg::state_t                 state_reg, state_next;
    logic [mme_pkg::CFG_W-1:0]       rows_a_reg, inner_len_reg, cols_b_reg;
    logic [mme_pkg::IDX_W-1:0]       row_reg, row_next;
    logic [DW-1:0]                   p_reg, p_next;
    logic [DW-1:0]                   j_reg, j_next;
    logic [SZW-1:0]                  m_eff, k_eff, n_eff;
    logic                            accept;
    logic                            row_bad;
    logic                            load_bad;
    logic                            last_p;
    logic                            last_col;

    function automatic logic [SZW-1:0] eff_size(input logic [mme_pkg::CFG_W-1:0] raw);
        if (raw == '0)
        begin
            eff_size = SZW'(1);
        end
        else if (32'(raw) > MAX_DIM)
        begin
            eff_size = SZW'(MAX_DIM);
        end
        else
        begin
            eff_size = SZW'(raw);
        end
    endfunction

    assign m_eff    = eff_size(rows_a_reg);
    assign k_eff    = eff_size(inner_len_reg);
    assign n_eff    = eff_size(cols_b_reg);
    assign accept   = request.valid && request.ready;
    assign row_bad  = 32'(request.row_index) >= 32'(m_eff);
    assign last_p   = (32'(p_reg) + 32'd1) == 32'(k_eff);
    assign last_col = (32'(j_reg) + 32'd1) == 32'(n_eff);
    assign row_sel  = row_reg;
    assign p_sel    = p_reg;
    assign j_sel    = j_reg;

    always_comb
    begin
        case (request.cmd)
            mme_pkg::CMD_LOAD_A:
            begin
                load_bad = row_bad
                        || (32'(request.col_index) >= 32'(k_eff));
            end
            mme_pkg::CMD_LOAD_B:
            begin
                load_bad = (32'(request.row_index) >= 32'(k_eff))
                        || (32'(request.col_index) >= 32'(n_eff));
            end
            default:
            begin
                load_bad = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mme_pkg::CFG_W'(1);
            inner_len_reg <= mme_pkg::CFG_W'(1);
            cols_b_reg    <= mme_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mme_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                mme_pkg::REG_INNER_LEN: inner_len_reg <= cfg_data;
                mme_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mme_pkg::ST_IDLE;
            row_reg   <= '0;
            p_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            p_reg     <= p_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.cmd)
                        mme_pkg::CMD_LOAD_A, mme_pkg::CMD_LOAD_B:
                        begin
                            if (load_bad)
                            begin
                                state_next = mme_pkg::ST_BAD;
                            end
                        end
                        mme_pkg::CMD_COMPUTE:
                        begin
                            if (row_bad)
                            begin
                                state_next = mme_pkg::ST_BAD;
                            end
                            else
                            begin
                                state_next = mme_pkg::ST_ISSUE;
                                row_next   = request.row_index;
                                p_next     = '0;
                                j_next     = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mme_pkg::ST_ISSUE:
            begin
                if (last_p)
                begin
                    p_next     = '0;
                    state_next = mme_pkg::ST_DRAIN;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            mme_pkg::ST_DRAIN:
            begin
                if (status.sum_done && status.out_free)
                begin
                    if (last_col)
                    begin
                        state_next = mme_pkg::ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = mme_pkg::ST_ISSUE;
                    end
                end
            end
            mme_pkg::ST_BAD:
            begin
                if (status.out_free)
                begin
                    state_next = mme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        request.ready = 1'b0;
        cmd.last_col  = last_col;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                request.ready = 1'b1;
                cmd.wr_a = accept && !load_bad && (request.cmd == mme_pkg::CMD_LOAD_A);
                cmd.wr_b = accept && !load_bad && (request.cmd == mme_pkg::CMD_LOAD_B);
            end
            mme_pkg::ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                cmd.first  = (p_reg == '0);
                cmd.last_p = last_p;
            end
            mme_pkg::ST_DRAIN:
            begin
                cmd.emit = status.sum_done && status.out_free;
            end
            mme_pkg::ST_BAD:
            begin
                cmd.emit_bad = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/mme_datapath.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply engine datapath
// Element memories, multiply and accumulate pipeline, and the output register.
// ----------------------------------------------------------------------------
module mme_datapath #(
    parameter int MAX_DIM = 16,
    parameter int ELEM_BITS = 16,
    localparam int DW = $clog2(MAX_DIM)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mme_pkg::mme_cmd_t             cmd,
    output mme_pkg::mme_status_t          status,
    input  logic [mme_pkg::IDX_W-1:0]     row_sel,
    input  logic [DW-1:0]                 p_sel,
    input  logic [DW-1:0]                 j_sel,
    input  logic [mme_pkg::IDX_W-1:0]     ld_row,
    input  logic [mme_pkg::IDX_W-1:0]     ld_col,
    input  logic signed [ELEM_BITS-1:0]   ld_element,
    mme_out_if.source                     response
);

    localparam int AW = 2 * DW;
    localparam int DEPTH = 1 << AW;

    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      a_rd_addr;
    logic [AW-1:0]                      b_rd_addr;
    logic [ELEM_BITS-1:0]               a_data;
    logic [ELEM_BITS-1:0]               b_data;
    logic                               s1_v_reg, s1_first_reg, s1_last_reg;
    logic                               s2_v_reg, s2_first_reg, s2_last_reg;
    logic signed [2*ELEM_BITS-1:0]      prod_reg;
    logic signed [mme_pkg::SUM_W-1:0]   acc_reg;
    logic signed [mme_pkg::SUM_W-1:0]   acc_base;
    logic                               sum_done_reg;
    logic                               out_valid_reg;
    logic [mme_pkg::IDX_W-1:0]          out_row_reg;
    logic [mme_pkg::IDX_W-1:0]          out_col_reg;
    logic signed [mme_pkg::SUM_W-1:0]   dot_sum_reg;
    logic                               last_reg;
    logic                               bad_reg;

    assign wr_addr   = {DW'(ld_row), DW'(ld_col)};
    assign a_rd_addr = {DW'(row_sel), p_sel};
    assign b_rd_addr = {p_sel, j_sel};

    mme_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (cmd.wr_a),
        .wr_addr (wr_addr),
        .wr_data (ld_element),
        .rd_addr (a_rd_addr),
        .rd_data (a_data)
    );

    mme_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (cmd.wr_b),
        .wr_addr (wr_addr),
        .wr_data (ld_element),
        .rd_addr (b_rd_addr),
        .rd_data (b_data)
    );

    assign acc_base = s2_first_reg ? '0 : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            sum_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
            if (s2_v_reg && s2_last_reg)
            begin
                sum_done_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                sum_done_reg <= 1'b0;
            end
            if (cmd.emit || cmd.emit_bad)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last_p;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        prod_reg     <= $signed(a_data) * $signed(b_data);
        if (s2_v_reg)
        begin
            acc_reg <= acc_base + mme_pkg::SUM_W'(prod_reg);
        end
        if (cmd.emit)
        begin
            out_row_reg <= row_sel;
            out_col_reg <= mme_pkg::IDX_W'(j_sel);
            dot_sum_reg <= acc_reg;
            last_reg    <= cmd.last_col;
            bad_reg     <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            out_row_reg <= '0;
            out_col_reg <= '0;
            dot_sum_reg <= '0;
            last_reg    <= 1'b0;
            bad_reg     <= 1'b1;
        end
    end

    assign status.sum_done   = sum_done_reg;
    assign status.out_free   = !out_valid_reg || response.ready;
    assign response.valid     = out_valid_reg;
    assign response.out_row   = out_row_reg;
    assign response.out_col   = out_col_reg;
    assign response.dot_sum   = dot_sum_reg;
    assign response.last      = last_reg;
    assign response.bad_index = bad_reg;

endmodule

// ===== rtl/core/matrix_multiply_engine_core.sv =====
// A load produces a transaction only when its index is out of range.
// A compute covers n columns with inner length k: one shared multiply-accumulate unit
// does one product per cycle within a column, and each product passes through the read,
// multiply and accumulate registers. A bad index answers once the output slot is free.
// Reset clears control state and sets all three size registers to 1; the element
// memories are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// Matrix multiply engine top level
// Computes one row of the product of stored matrices A and B per compute
// transaction, with elements loaded one at a time.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_core_assert.svh"

module matrix_multiply_engine_core #(
    parameter int MAX_DIM = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]        cfg_data,
    mme_in_if.sink                           request,
    mme_out_if.source                        response
);

    localparam int DW = $clog2(MAX_DIM);

    mme_pkg::mme_cmd_t              ctrl_cmd;
    mme_pkg::mme_status_t           ctrl_status;
    logic [mme_pkg::IDX_W-1:0]      row_sel;
    logic [DW-1:0]                  p_sel;
    logic [DW-1:0]                  j_sel;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (ctrl_cmd),
        .status    (ctrl_status),
        .row_sel   (row_sel),
        .p_sel     (p_sel),
        .j_sel     (j_sel)
    );

    mme_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .status     (ctrl_status),
        .row_sel    (row_sel),
        .p_sel      (p_sel),
        .j_sel      (j_sel),
        .ld_row     (request.row_index),
        .ld_col     (request.col_index),
        .ld_element (request.element),
        .response   (response)
    );

    `MME_ASSERT_NOW(a_emit_slot_free, ctrl_cmd.emit || ctrl_cmd.emit_bad,
        !response.valid || response.ready, "Result loaded over a pending transaction.")
    `MME_ASSERT_NEXT(a_last_column_shown, ctrl_cmd.emit && ctrl_cmd.last_col,
        response.valid && response.last && !response.bad_index, "Last column not marked.")
    `MME_ASSERT_NOW(a_busy_blocks_input, ctrl_cmd.issue || ctrl_status.sum_done,
        !request.ready, "Request accepted during a row computation.")
    `MME_ASSERT_NOW(a_bad_result_clear, response.valid && response.bad_index,
        response.dot_sum == '0 && !response.last, "Error transaction carries data.")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads elements of A and B, requests product rows, and checks every response
// transaction against a row-at-a-time product worked out inside the bench.
// Directed loads and computes at the element extremes and with bad indexes
// come first. A full 16x16x16 phase follows, then short phases under a
// matrix-vector shape, a one-row shape with sixteen columns and random sizes,
// several of them with out-of-range register values. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_DIM = 16;
    localparam int ELEM_BITS = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int TAIL_CYCLES = 320;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                  cmd;
        logic [mme_pkg::IDX_W-1:0]   row;
        logic [mme_pkg::IDX_W-1:0]   col;
        logic signed [ELEM_BITS-1:0] value;
    } request_t;

    typedef struct {
        logic [mme_pkg::IDX_W-1:0]        row;
        logic [mme_pkg::IDX_W-1:0]        col;
        logic signed [mme_pkg::SUM_W-1:0] sum;
        logic                             last;
        logic                             bad;
    } product_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [mme_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mme_pkg::CFG_W-1:0]     cfg_data;

    mme_in_if #(.ELEM_BITS(ELEM_BITS)) request_bus ();
    mme_out_if response_bus ();

    matrix_multiply_engine_core #(
        .MAX_DIM(MAX_DIM),
        .ELEM_BITS(ELEM_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .request(request_bus),
        .response(response_bus)
    );

    request_t                    queued_requests[$];
    product_t                    awaited_products[$];
    request_t                    accepted_request;
    request_t                    staged_request;
    logic [mme_pkg::CFG_W-1:0]   size_regs [3];
    logic signed [ELEM_BITS-1:0] a_elems [MAX_DIM*MAX_DIM];
    logic signed [ELEM_BITS-1:0] b_elems [MAX_DIM*MAX_DIM];
    bit                          a_planned [MAX_DIM*MAX_DIM];
    bit                          b_planned [MAX_DIM*MAX_DIM];
    int                          plan_m = 1;
    int                          plan_k = 1;
    int                          plan_n = 1;
    int                          pushed = 0;
    int                          send_idle_pct = 14;
    int                          recv_stall_pct = 69;
    int                          mismatches = 0;
    int                          cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [mme_pkg::CFG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return raw;
    endfunction

    function automatic logic signed [ELEM_BITS-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return ELEM_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [mme_pkg::CFG_W-1:0] pick_size();
        if ($urandom_range(0, 3) == 0)
            return mme_pkg::CFG_W'($urandom_range(0, 31));
        return mme_pkg::CFG_W'($urandom_range(1, 5));
    endfunction

    // Applies one accepted transaction to the element stores and queues the
    // product row or the index error that it must produce.
    function automatic void forecast_products(input request_t rq);
        int m;
        int k;
        int n;
        int rlim;
        int clim;
        int j;
        int q;
        logic signed [mme_pkg::SUM_W-1:0] acc;
        product_t res;
        m = eff_dim(size_regs[mme_pkg::REG_ROWS_A]);
        k = eff_dim(size_regs[mme_pkg::REG_INNER_LEN]);
        n = eff_dim(size_regs[mme_pkg::REG_COLS_B]);
        res = '{default: '0};
        case (rq.cmd)
            mme_pkg::CMD_LOAD_A, mme_pkg::CMD_LOAD_B:
            begin
                rlim = (rq.cmd == mme_pkg::CMD_LOAD_A) ? m : k;
                clim = (rq.cmd == mme_pkg::CMD_LOAD_A) ? k : n;
                if (rq.row >= rlim || rq.col >= clim)
                begin
                    res.bad = 1'b1;
                    awaited_products.push_back(res);
                end
                else if (rq.cmd == mme_pkg::CMD_LOAD_A)
                    a_elems[rq.row*MAX_DIM + rq.col] = rq.value;
                else
                    b_elems[rq.row*MAX_DIM + rq.col] = rq.value;
            end
            mme_pkg::CMD_COMPUTE:
            begin
                if (rq.row >= m)
                begin
                    res.bad = 1'b1;
                    awaited_products.push_back(res);
                end
                else
                begin
                    for (j = 0; j < n; j++)
                    begin
                        acc = '0;
                        for (q = 0; q < k; q++)
                            acc = acc + a_elems[rq.row*MAX_DIM + q] * b_elems[q*MAX_DIM + j];
                        res.row = rq.row;
                        res.col = mme_pkg::IDX_W'(j);
                        res.sum = acc;
                        res.last = (j == n - 1);
                        awaited_products.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_bus.valid <= 1'b0;
            request_bus.cmd <= '0;
            request_bus.row_index <= '0;
            request_bus.col_index <= '0;
            request_bus.element <= '0;
        end
        else if (!request_bus.valid || request_bus.ready)
        begin
            if (request_bus.valid)
            begin
                accepted_request = '{request_bus.cmd, request_bus.row_index,
                                     request_bus.col_index, request_bus.element};
                forecast_products(accepted_request);
            end
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                staged_request = queued_requests.pop_front();
                request_bus.valid <= 1'b1;
                request_bus.cmd <= staged_request.cmd;
                request_bus.row_index <= staged_request.row;
                request_bus.col_index <= staged_request.col;
                request_bus.element <= staged_request.value;
            end
            else
                request_bus.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            response_bus.ready <= 1'b0;
        else
            response_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string text);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, text);
    endtask

    always @(posedge clk)
    begin
        product_t got;
        product_t oldest;
        if (rst_n && response_bus.valid && response_bus.ready)
        begin
            got = '{response_bus.out_row, response_bus.out_col, response_bus.dot_sum,
                    response_bus.last, response_bus.bad_index};
            if (awaited_products.size() == 0)
                report_mismatch($sformatf({"unexpected transaction: row %0d col %0d",
                                           " sum %0d last %0b bad %0b"},
                                          got.row, got.col, got.sum, got.last, got.bad));
            else
            begin
                oldest = awaited_products.pop_front();
                if (got.row !== oldest.row || got.col !== oldest.col || got.sum !== oldest.sum
                    || got.last !== oldest.last || got.bad !== oldest.bad)
                    report_mismatch($sformatf({"wrong transaction: expected row %0d col %0d sum %0d",
                                               " last %0b bad %0b, got row %0d col %0d sum %0d",
                                               " last %0b bad %0b"},
                                              oldest.row, oldest.col, oldest.sum, oldest.last,
                                              oldest.bad, got.row, got.col, got.sum, got.last,
                                              got.bad));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_size(input logic [mme_pkg::CFG_IDX_W-1:0] index,
                              input logic [mme_pkg::CFG_W-1:0] raw);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_regs[index] = raw;
    endtask

    task automatic wait_drained(input int extra);
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || request_bus.valid || awaited_products.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    function automatic void enqueue_request(input request_t rq);
        int rlim;
        int clim;
        if (rq.cmd == mme_pkg::CMD_LOAD_A || rq.cmd == mme_pkg::CMD_LOAD_B)
        begin
            rlim = (rq.cmd == mme_pkg::CMD_LOAD_A) ? plan_m : plan_k;
            clim = (rq.cmd == mme_pkg::CMD_LOAD_A) ? plan_k : plan_n;
            if (rq.row < rlim && rq.col < clim)
            begin
                if (rq.cmd == mme_pkg::CMD_LOAD_A)
                    a_planned[rq.row*MAX_DIM + rq.col] = 1'b1;
                else
                    b_planned[rq.row*MAX_DIM + rq.col] = 1'b1;
            end
        end
        queued_requests.push_back(rq);
        pushed++;
    endfunction

    // Loads whatever row i of the product still needs, plus a few reloads,
    // in shuffled order, and then asks for the row.
    function automatic void queue_row_job(input int i);
        request_t batch[$];
        request_t tmp;
        int q;
        int j;
        int s;
        for (q = 0; q < plan_k; q++)
            if (!a_planned[i*MAX_DIM + q] || $urandom_range(0, 99) < 15)
                batch.push_back('{mme_pkg::CMD_LOAD_A, mme_pkg::IDX_W'(i),
                                  mme_pkg::IDX_W'(q), pick_element()});
        for (q = 0; q < plan_k; q++)
            for (j = 0; j < plan_n; j++)
                if (!b_planned[q*MAX_DIM + j] || $urandom_range(0, plan_k*plan_n) < 2)
                    batch.push_back('{mme_pkg::CMD_LOAD_B, mme_pkg::IDX_W'(q),
                                      mme_pkg::IDX_W'(j), pick_element()});
        for (s = batch.size() - 1; s > 0; s--)
        begin
            j = $urandom_range(0, s);
            tmp = batch[s];
            batch[s] = batch[j];
            batch[j] = tmp;
        end
        for (s = 0; s < batch.size(); s++)
            enqueue_request(batch[s]);
        enqueue_request('{mme_pkg::CMD_COMPUTE, mme_pkg::IDX_W'(i), mme_pkg::IDX_W'($urandom),
                          ELEM_BITS'($urandom)});
    endfunction

    task automatic run_phase(input logic [mme_pkg::CFG_W-1:0] raw_m,
                             input logic [mme_pkg::CFG_W-1:0] raw_k,
                             input logic [mme_pkg::CFG_W-1:0] raw_n, input int budget,
                             input int send_pct, input int recv_pct);
        int start;
        int pick;
        int rlim;
        int clim;
        logic [1:0] cmd;
        logic [mme_pkg::IDX_W-1:0] row;
        logic [mme_pkg::IDX_W-1:0] col;
        wait_drained(DRAIN_CYCLES);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_size(mme_pkg::REG_ROWS_A, raw_m);
        write_size(mme_pkg::REG_INNER_LEN, raw_k);
        write_size(mme_pkg::REG_COLS_B, raw_n);
        plan_m = eff_dim(raw_m);
        plan_k = eff_dim(raw_k);
        plan_n = eff_dim(raw_n);
        start = pushed;
        while (pushed - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5 || (pick == 8 && plan_m == MAX_DIM))
                queue_row_job($urandom_range(0, plan_m - 1));
            else if (pick == 6)
            begin
                if ($urandom_range(0, 1))
                    enqueue_request('{mme_pkg::CMD_LOAD_A,
                                      mme_pkg::IDX_W'($urandom_range(0, plan_m - 1)),
                                      mme_pkg::IDX_W'($urandom_range(0, plan_k - 1)),
                                      pick_element()});
                else
                    enqueue_request('{mme_pkg::CMD_LOAD_B,
                                      mme_pkg::IDX_W'($urandom_range(0, plan_k - 1)),
                                      mme_pkg::IDX_W'($urandom_range(0, plan_n - 1)),
                                      pick_element()});
            end
            else if (pick == 7)
            begin
                cmd = $urandom_range(0, 1) ? mme_pkg::CMD_LOAD_B : mme_pkg::CMD_LOAD_A;
                rlim = (cmd == mme_pkg::CMD_LOAD_A) ? plan_m : plan_k;
                clim = (cmd == mme_pkg::CMD_LOAD_A) ? plan_k : plan_n;
                row = mme_pkg::IDX_W'($urandom);
                col = mme_pkg::IDX_W'($urandom);
                if (rlim < MAX_DIM && (clim == MAX_DIM || $urandom_range(0, 1)))
                    row = mme_pkg::IDX_W'($urandom_range(rlim, MAX_DIM - 1));
                else if (clim < MAX_DIM)
                    col = mme_pkg::IDX_W'($urandom_range(clim, MAX_DIM - 1));
                enqueue_request('{cmd, row, col, pick_element()});
            end
            else if (pick == 8)
                enqueue_request('{mme_pkg::CMD_COMPUTE,
                                  mme_pkg::IDX_W'($urandom_range(plan_m, MAX_DIM - 1)),
                                  mme_pkg::IDX_W'($urandom), ELEM_BITS'($urandom)});
            else
                enqueue_request('{CMD_UNUSED, mme_pkg::IDX_W'($urandom),
                                  mme_pkg::IDX_W'($urandom), ELEM_BITS'($urandom)});
        end
    endtask

    initial
    begin
        int ph;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        request_bus.valid = 1'b0;
        request_bus.cmd = '0;
        request_bus.row_index = '0;
        request_bus.col_index = '0;
        request_bus.element = '0;
        response_bus.ready = 1'b0;
        size_regs[mme_pkg::REG_ROWS_A] = 1;
        size_regs[mme_pkg::REG_INNER_LEN] = 1;
        size_regs[mme_pkg::REG_COLS_B] = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All sizes are one after reset, so this is a plain dot product of length one.
        enqueue_request('{mme_pkg::CMD_LOAD_A, 4'd0, 4'd0, 16'h8000});
        enqueue_request('{mme_pkg::CMD_LOAD_B, 4'd0, 4'd0, 16'h8000});
        enqueue_request('{mme_pkg::CMD_COMPUTE, 4'd0, 4'd15, 16'hFFFF});
        enqueue_request('{mme_pkg::CMD_LOAD_A, 4'd0, 4'd0, 16'h7FFF});
        enqueue_request('{mme_pkg::CMD_COMPUTE, 4'd0, 4'd0, 16'h0000});
        enqueue_request('{mme_pkg::CMD_LOAD_B, 4'd0, 4'd0, 16'h7FFF});
        enqueue_request('{mme_pkg::CMD_COMPUTE, 4'd0, 4'd0, 16'h0000});
        enqueue_request('{mme_pkg::CMD_LOAD_A, 4'd15, 4'd0, 16'h1234});
        enqueue_request('{mme_pkg::CMD_LOAD_A, 4'd0, 4'd15, 16'hFFFF});
        enqueue_request('{mme_pkg::CMD_LOAD_B, 4'd15, 4'd15, 16'h8000});
        enqueue_request('{mme_pkg::CMD_LOAD_B, 4'd0, 4'd1, 16'h0001});
        enqueue_request('{mme_pkg::CMD_COMPUTE, 4'd15, 4'd15, 16'hFFFF});
        enqueue_request('{CMD_UNUSED, 4'd15, 4'd15, 16'hFFFF});
        enqueue_request('{CMD_UNUSED, 4'd0, 4'd0, 16'h0000});
        enqueue_request('{mme_pkg::CMD_COMPUTE, 4'd0, 4'd0, 16'h0000});

        run_phase(5'd16, 5'd16, 5'd16, 250, 14, 69);

        run_phase(5'd31, 5'd3, 5'd0, 6, 69, 14);
        run_phase(5'd0, 5'd1, 5'd17, 6, 69, 14);

        for (ph = 0; ph < 2; ph++)
            run_phase(pick_size(), pick_size(), pick_size(), 6, 0, 0);

        wait_drained(TAIL_CYCLES);
        if (mismatches == 0 && awaited_products.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
